// File: hw/rtl/rau_pkg.sv
// Shared types, constants and helper functions for the rotor angle unwrap block.
package rau_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int POS_BITS   = 32;
    localparam int PP_BITS    = 7;
    localparam int OP_BITS    = 2;
    localparam int CODE_BITS  = 3;
    localparam int ST_BITS    = 3;
    // Signed step width: holds the raw difference and the folded step.
    localparam int DELTA_BITS = ANGLE_BITS + 2;

    localparam logic [PP_BITS-1:0] PP_RESET = PP_BITS'(1);

    localparam logic [OP_BITS-1:0] OP_SAMPLE    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ_FAIL = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CALIBRATE = 2'd2;
    localparam logic [OP_BITS-1:0] OP_UNUSED    = 2'd3;

    localparam logic [CODE_BITS-1:0] MAG_OK        = 3'd0;
    localparam logic [CODE_BITS-1:0] MAG_NONE      = 3'd1;
    localparam logic [CODE_BITS-1:0] MAG_WEAK      = 3'd2;
    localparam logic [CODE_BITS-1:0] MAG_STRONG    = 3'd3;
    localparam logic [CODE_BITS-1:0] MAG_READ_FAIL = 3'd4;

    localparam logic [ST_BITS-1:0] ST_UNINIT    = 3'd0;
    localparam logic [ST_BITS-1:0] ST_OK        = 3'd1;
    localparam logic [ST_BITS-1:0] ST_NO_MAGNET = 3'd2;
    localparam logic [ST_BITS-1:0] ST_WEAK      = 3'd3;
    localparam logic [ST_BITS-1:0] ST_STRONG    = 3'd4;
    localparam logic [ST_BITS-1:0] ST_IO_ERROR  = 3'd5;

    localparam logic signed [DELTA_BITS-1:0] HALF_TURN =
        DELTA_BITS'(1 << (ANGLE_BITS - 1));
    localparam logic signed [DELTA_BITS-1:0] FULL_TURN =
        DELTA_BITS'(1 << ANGLE_BITS);

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [ANGLE_BITS-1:0] raw_angle;
        logic                  diag_valid;
        logic [CODE_BITS-1:0]  magnet_code;
        logic [ANGLE_BITS-1:0] target_angle;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] last_angle;
        logic [POS_BITS-1:0]   turn_position;
        logic                  sample_seen;
        logic [ANGLE_BITS-1:0] zero_offset;
        logic                  zero_set;
        logic [ST_BITS-1:0]    status_code;
    } t_state;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]      angle_now;
        logic signed [POS_BITS-1:0] position;
        logic [ANGLE_BITS-1:0]      elec_unaligned;
        logic [ANGLE_BITS-1:0]      elec_aligned;
        logic [ANGLE_BITS-1:0]      zero_value;
        logic                       zero_done;
        logic [ST_BITS-1:0]         health;
        logic                       have_sample;
        logic                       cal_accepted;
    } t_out_item;

    // Magnet status code to block status; unknown codes count as a read error.
    function automatic logic [ST_BITS-1:0] map_code(input logic [CODE_BITS-1:0] code);
        logic [ST_BITS-1:0] st;
        unique case (code)
            MAG_OK:     st = ST_OK;
            MAG_NONE:   st = ST_NO_MAGNET;
            MAG_WEAK:   st = ST_WEAK;
            MAG_STRONG: st = ST_STRONG;
            default:    st = ST_IO_ERROR;
        endcase
        return st;
    endfunction

endpackage

// File: hw/rtl/rau_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface rau_in_if;
    logic                              valid;
    logic                              ready;
    logic [rau_pkg::OP_BITS-1:0]       op;
    logic [rau_pkg::ANGLE_BITS-1:0]    raw_angle;
    logic                              diag_valid;
    logic [rau_pkg::CODE_BITS-1:0]     magnet_code;
    logic [rau_pkg::ANGLE_BITS-1:0]    target_angle;

    modport source (output valid, op, raw_angle, diag_valid, magnet_code, target_angle,
                    input ready);
    modport sink (input valid, op, raw_angle, diag_valid, magnet_code, target_angle,
                  output ready);
endinterface

interface rau_out_if;
    logic                              valid;
    logic                              ready;
    logic [rau_pkg::ANGLE_BITS-1:0]    angle_now;
    logic signed [rau_pkg::POS_BITS-1:0] position;
    logic [rau_pkg::ANGLE_BITS-1:0]    elec_unaligned;
    logic [rau_pkg::ANGLE_BITS-1:0]    elec_aligned;
    logic [rau_pkg::ANGLE_BITS-1:0]    zero_value;
    logic                              zero_done;
    logic [rau_pkg::ST_BITS-1:0]       health;
    logic                              have_sample;
    logic                              cal_accepted;

    modport source (output valid, angle_now, position, elec_unaligned, elec_aligned,
                    zero_value, zero_done, health, have_sample, cal_accepted,
                    input ready);
    modport sink (input valid, angle_now, position, elec_unaligned, elec_aligned,
                  zero_value, zero_done, health, have_sample, cal_accepted,
                  output ready);
endinterface

// File: hw/rtl/rau_step.sv
// Combinational update of the unwrap state and the result for one transaction.
module rau_step (
    input  rau_pkg::t_in_item                  i_item,
    input  rau_pkg::t_state                    i_state,
    input  logic [rau_pkg::PP_BITS-1:0]        i_pole_pairs,
    output rau_pkg::t_state                    o_next,
    output rau_pkg::t_out_item                 o_result
);

    logic signed [rau_pkg::DELTA_BITS-1:0] diff;
    logic signed [rau_pkg::DELTA_BITS-1:0] step;
    logic [rau_pkg::ANGLE_BITS-1:0]        mul_src;
    logic [rau_pkg::ANGLE_BITS+rau_pkg::PP_BITS-1:0] product;
    logic [rau_pkg::ANGLE_BITS-1:0]        elec;
    logic                                  cal_ok;

    // Shortest signed step between readings, folded into half a turn either way.
    assign diff = $signed({2'b00, i_item.raw_angle}) - $signed({2'b00, i_state.last_angle});

    always_comb begin
        priority if (diff > rau_pkg::HALF_TURN) begin
            step = diff - rau_pkg::FULL_TURN;
        end else if (diff < -rau_pkg::HALF_TURN) begin
            step = diff + rau_pkg::FULL_TURN;
        end else begin
            step = diff;
        end
    end

    // One multiplier serves both the new sample and the calibration angle.
    assign mul_src = (i_item.op == rau_pkg::OP_SAMPLE) ? i_item.raw_angle : i_state.last_angle;
    assign product = mul_src * i_pole_pairs;
    assign elec    = product[rau_pkg::ANGLE_BITS-1:0];

    assign cal_ok = i_state.sample_seen &&
                    (i_state.status_code == rau_pkg::ST_OK ||
                     i_state.status_code == rau_pkg::ST_WEAK ||
                     i_state.status_code == rau_pkg::ST_STRONG);

    always_comb begin
        o_next = i_state;
        o_result.cal_accepted = 1'b0;
        unique case (i_item.op)
            rau_pkg::OP_SAMPLE: begin
                if (i_state.sample_seen) begin
                    o_next.turn_position = i_state.turn_position +
                        {{(rau_pkg::POS_BITS-rau_pkg::DELTA_BITS){step[rau_pkg::DELTA_BITS-1]}},
                         step};
                end else begin
                    o_next.turn_position = rau_pkg::POS_BITS'(i_item.raw_angle);
                end
                o_next.last_angle  = i_item.raw_angle;
                o_next.sample_seen = 1'b1;
                if (i_item.diag_valid) begin
                    o_next.status_code = rau_pkg::map_code(i_item.magnet_code);
                end
            end
            rau_pkg::OP_READ_FAIL: begin
                o_next.status_code = rau_pkg::ST_IO_ERROR;
            end
            rau_pkg::OP_CALIBRATE: begin
                if (cal_ok) begin
                    o_next.zero_offset    = elec - i_item.target_angle;
                    o_next.zero_set       = 1'b1;
                    o_result.cal_accepted = 1'b1;
                end
            end
            rau_pkg::OP_UNUSED: begin
            end
            default: begin
            end
        endcase

        // The multiplier output already reflects the angle held after this transaction.
        o_result.angle_now      = o_next.last_angle;
        o_result.position       = $signed(o_next.turn_position);
        o_result.elec_unaligned = elec;
        o_result.elec_aligned   = elec - o_next.zero_offset;
        o_result.zero_value     = o_next.zero_offset;
        o_result.zero_done      = o_next.zero_set;
        o_result.health         = o_next.status_code;
        o_result.have_sample    = o_next.sample_seen;
    end

endmodule

// File: hw/rtl/rotor_angle_unwrap_electrical.sv
// Top level of the rotor angle unwrap block with electrical angle and zero calibration.
// A result transaction passes from the input register into the result register, where it is offered;
// a stall on the result side can hold it in the input register before it moves on.
// Throughput: one transaction per cycle, set by the single-pass update between the input
// register and the result register; backpressure from the result side stalls a full input stage.
// Reset (synchronous, active low) clears the unwrap state, both valid flags and sets pole pairs to 1.
module rotor_angle_unwrap_electrical (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rau_pkg::PP_BITS-1:0]    i_cfg_wdata,
    rau_in_if.sink                         i_in,
    rau_out_if.source                      o_out
);

    // Configuration register: pole pairs.
    logic [rau_pkg::PP_BITS-1:0] r_pole_pairs;

    // Input stage: one accepted transaction waiting for its update.
    logic              r_in_vld;
    rau_pkg::t_in_item r_in;

    // Architectural state of the unwrap, updated when the input stage advances.
    rau_pkg::t_state   r_state;
    rau_pkg::t_state   n_state;

    // Result stage, which decouples the result consumer from the input side.
    logic               r_out_vld;
    rau_pkg::t_out_item r_out;
    rau_pkg::t_out_item n_out;

    logic adv;
    logic in_fire;

    // The input stage moves on whenever the result register is free or being drained.
    assign adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;
    assign in_fire  = i_in.valid && i_in.ready;

    rau_step u_step (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_pole_pairs (r_pole_pairs),
        .o_next       (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_pairs <= rau_pkg::PP_RESET;
        end else if (i_cfg_we) begin
            r_pole_pairs <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    // Payload of the input stage needs no reset; it is qualified by r_in_vld.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.op           <= i_in.op;
            r_in.raw_angle    <= i_in.raw_angle;
            r_in.diag_valid   <= i_in.diag_valid;
            r_in.magnet_code  <= i_in.magnet_code;
            r_in.target_angle <= i_in.target_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.angle_now      = r_out.angle_now;
    assign o_out.position       = r_out.position;
    assign o_out.elec_unaligned = r_out.elec_unaligned;
    assign o_out.elec_aligned   = r_out.elec_aligned;
    assign o_out.zero_value     = r_out.zero_value;
    assign o_out.zero_done      = r_out.zero_done;
    assign o_out.health         = r_out.health;
    assign o_out.have_sample    = r_out.have_sample;
    assign o_out.cal_accepted   = r_out.cal_accepted;

    // A successful calibration always leaves a calibrated zero and a valid sample behind.
    a_cal_implies_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.cal_accepted |-> o_out.zero_done && o_out.have_sample)
        else $error("calibration reported without zero set or sample");

    // The unwrap state changes only when a transaction is processed.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_state))
        else $error("unwrap state changed without a processed transaction");

    // A stalled result is not dropped.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld)
        else $error("result dropped while stalled");

    // Once a sample has been seen, later results keep reporting it.
    a_sample_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_state.sample_seen |-> n_state.sample_seen)
        else $error("sample flag cleared");

endmodule
